/* rtl/core/window_peak_count_max_macros.svh */
// ----------------------------------------------------------------------------
// window_peak_count_max_macros.svh
// Assertion macros shared by the sliding-window peak counter.
// ----------------------------------------------------------------------------
`ifndef WINDOW_PEAK_COUNT_MAX_MACROS_SVH
`define WINDOW_PEAK_COUNT_MAX_MACROS_SVH

// Same-cycle implication, sampled on clk, off while rst_n is low.
`define WPC_ASSERT_NOW(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, sampled on clk, off while rst_n is low.
`define WPC_ASSERT_NEXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

/* rtl/core/wpc_pkg.sv */
// ----------------------------------------------------------------------------
// wpc_pkg
// Fixed field widths and the control beat passed from front to tracker.
// ----------------------------------------------------------------------------
package wpc_pkg;

    localparam int WLEN_W     = 11;
    localparam int PARTS_W    = 10;
    localparam int START_W    = 17;
    localparam int MIN_WINDOW = 3;

    typedef struct packed {
        logic               last;
        logic               do_add;
        logic               do_rem;
        logic               do_best;
        logic               peak;
        logic               too_short;
        logic [START_W-1:0] start;
    } ctl_t;

endpackage

/* rtl/core/wpc_if.sv */
// ----------------------------------------------------------------------------
// wpc_if
// Valid/ready channels: sample input, result output, window length write.
// ----------------------------------------------------------------------------
interface wpc_sample_if #(
    parameter int SAMPLE_BITS = 32
);
    logic                          valid;
    logic                          ready;
    logic signed [SAMPLE_BITS-1:0] sample;
    logic                          last;

    modport source (output valid, output sample, output last, input ready);
    modport sink   (input valid, input sample, input last, output ready);
endinterface

interface wpc_result_if;
    import wpc_pkg::*;

    logic               valid;
    logic               ready;
    logic [PARTS_W-1:0] parts;
    logic [START_W-1:0] start_res;
    logic               too_short;

    modport source (output valid, output parts, output start_res, output too_short,
                    input ready);
    modport sink   (input valid, input parts, input start_res, input too_short,
                    output ready);
endinterface

interface wpc_cfg_if;
    import wpc_pkg::*;

    logic              valid;
    logic              ready;
    logic [WLEN_W-1:0] window_len;

    modport source (output valid, output window_len, input ready);
    modport sink   (input valid, input window_len, output ready);
endinterface

/* rtl/core/wpc_ring.sv */
// ----------------------------------------------------------------------------
// wpc_ring
// Peak-bit ring: one write port, one read port, registered read data.
// ----------------------------------------------------------------------------
module wpc_ring #(
    parameter int DEPTH = 1024
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic                     wdata,
    input  logic                     re,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic                     rdata
);
    logic mem [DEPTH];
    logic rdata_reg;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        if (re)
        begin
            rdata_reg <= mem[raddr];
        end
    end

    assign rdata = rdata_reg;
endmodule

/* rtl/core/wpc_front.sv */
// ----------------------------------------------------------------------------
// wpc_front
// Sample stage: peak detect, stream position, ring pointers, control beat.
// ----------------------------------------------------------------------------
module wpc_front #(
    parameter int MAX_WINDOW  = 1024,
    parameter int MAX_LENGTH  = 65536,
    parameter int SAMPLE_BITS = 32
) (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          accept,
    input  logic                          stall,
    input  logic signed [SAMPLE_BITS-1:0] sample,
    input  logic                          last,
    input  logic [wpc_pkg::WLEN_W-1:0]    window_len,
    output logic                          ring_we,
    output logic [$clog2(MAX_WINDOW)-1:0] ring_waddr,
    output logic                          ring_wdata,
    output logic                          ring_re,
    output logic [$clog2(MAX_WINDOW)-1:0] ring_raddr,
    output logic                          ctl_valid,
    output wpc_pkg::ctl_t                 ctl
);
    import wpc_pkg::*;

    localparam int AW    = $clog2(MAX_WINDOW);
    localparam int POS_W = $clog2(MAX_LENGTH + 1);
    localparam int WIN_W = $clog2(MAX_WINDOW + 1);
    localparam int CLW   = (WIN_W > WLEN_W) ? WIN_W : WLEN_W;
    localparam int CW    = ((POS_W > WIN_W) ? POS_W : WIN_W) + 1;

    logic [POS_W-1:0]             pos_reg, pos_next;
    logic [WIN_W-1:0]             win_reg, win_next;
    logic [AW-1:0]                wr_ptr_reg, wr_ptr_next;
    logic [AW-1:0]                rd_ptr_reg, rd_ptr_next;
    logic signed [SAMPLE_BITS-1:0] prev1_reg, prev1_next;
    logic signed [SAMPLE_BITS-1:0] prev2_reg, prev2_next;
    logic                         ctl_valid_reg, ctl_valid_next;
    ctl_t                         ctl_reg, ctl_next;

    logic [CLW-1:0] wl_ext;
    logic [WIN_W-1:0] win_clamp, win_eff;
    logic [CW-1:0]  p_ext, p_inc, w_ext, pos_after, start_full;
    logic           active, do_add, do_rem, do_best, peak;

    // Clamp the register into 3 .. MAX_WINDOW
    always_comb
    begin
        wl_ext = CLW'(window_len);
        if (wl_ext < CLW'(MIN_WINDOW))
        begin
            win_clamp = WIN_W'(MIN_WINDOW);
        end
        else if (wl_ext > CLW'(MAX_WINDOW))
        begin
            win_clamp = WIN_W'(MAX_WINDOW);
        end
        else
        begin
            win_clamp = WIN_W'(wl_ext);
        end
    end

    always_comb
    begin
        active     = (pos_reg < POS_W'(MAX_LENGTH));
        win_eff    = (pos_reg == '0) ? win_clamp : win_reg;
        p_ext      = CW'(pos_reg);
        p_inc      = p_ext + CW'(1);
        w_ext      = CW'(win_eff);
        do_add     = active && (p_ext >= CW'(2));
        do_rem     = do_add && (p_ext >= w_ext);
        do_best    = active && (p_inc >= w_ext);
        pos_after  = active ? p_inc : p_ext;
        start_full = p_inc - w_ext;
        peak       = (prev1_reg > prev2_reg) && (prev1_reg > sample);
    end

    assign ring_we    = accept && do_add;
    assign ring_waddr = wr_ptr_reg;
    assign ring_wdata = peak;
    assign ring_re    = accept && do_rem;
    assign ring_raddr = rd_ptr_reg;

    always_comb
    begin
        pos_next    = pos_reg;
        win_next    = win_reg;
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        prev1_next  = prev1_reg;
        prev2_next  = prev2_reg;
        ctl_next    = ctl_reg;
        ctl_valid_next = stall ? ctl_valid_reg : 1'b0;

        if (accept)
        begin
            ctl_valid_next     = 1'b1;
            ctl_next.last      = last;
            ctl_next.do_add    = do_add;
            ctl_next.do_rem    = do_rem;
            ctl_next.do_best   = do_best;
            ctl_next.peak      = peak;
            ctl_next.too_short = (pos_after < w_ext);
            ctl_next.start     = START_W'(start_full);

            if (last)
            begin
                // start the next stream from scratch
                pos_next    = '0;
                wr_ptr_next = AW'(1);
                rd_ptr_next = AW'(1);
            end
            else if (active)
            begin
                pos_next   = POS_W'(p_inc);
                win_next   = win_eff;
                prev2_next = prev1_reg;
                prev1_next = sample;
                if (do_add)
                begin
                    wr_ptr_next = (wr_ptr_reg == AW'(MAX_WINDOW - 1)) ? '0
                                                                      : wr_ptr_reg + AW'(1);
                end
                if (do_rem)
                begin
                    rd_ptr_next = (rd_ptr_reg == AW'(MAX_WINDOW - 1)) ? '0
                                                                      : rd_ptr_reg + AW'(1);
                end
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pos_reg       <= '0;
            win_reg       <= WIN_W'(MIN_WINDOW);
            wr_ptr_reg    <= AW'(1);
            rd_ptr_reg    <= AW'(1);
            ctl_valid_reg <= 1'b0;
        end
        else
        begin
            pos_reg       <= pos_next;
            win_reg       <= win_next;
            wr_ptr_reg    <= wr_ptr_next;
            rd_ptr_reg    <= rd_ptr_next;
            ctl_valid_reg <= ctl_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        prev1_reg <= prev1_next;
        prev2_reg <= prev2_next;
        ctl_reg   <= ctl_next;
    end

    assign ctl_valid = ctl_valid_reg;
    assign ctl       = ctl_reg;
endmodule

/* rtl/core/wpc_track.sv */
// ----------------------------------------------------------------------------
// wpc_track
// Window count update, running best, result register.
// ----------------------------------------------------------------------------
module wpc_track #(
    parameter int MAX_WINDOW = 1024
) (
    input  logic                        clk,
    input  logic                        rst_n,
    input  logic                        ctl_valid,
    input  wpc_pkg::ctl_t               ctl,
    input  logic                        ring_bit,
    input  logic                        out_ready,
    output logic                        stall,
    output logic                        out_valid,
    output logic [wpc_pkg::PARTS_W-1:0] parts,
    output logic [wpc_pkg::START_W-1:0] start_res,
    output logic                        too_short
);
    import wpc_pkg::*;

    localparam int CNT_W = $clog2(MAX_WINDOW + 1);

    logic [CNT_W-1:0]   cnt_reg, cnt_next;
    logic [CNT_W-1:0]   best_reg, best_next;
    logic [START_W-1:0] bstart_reg, bstart_next;
    logic               out_valid_reg, out_valid_next;
    logic [PARTS_W-1:0] parts_reg, parts_next;
    logic [START_W-1:0] start_res_reg, start_res_next;
    logic               too_short_reg, too_short_next;

    logic               go;
    logic [CNT_W-1:0]   cnt_upd, best_upd;
    logic [START_W-1:0] bstart_upd;
    logic [CNT_W:0]     best_inc;
    logic               better;

    // Hold a finished stream while the previous result still waits
    assign stall = ctl_valid && ctl.last && out_valid_reg && !out_ready;
    assign go    = ctl_valid && !stall;

    always_comb
    begin
        cnt_upd = cnt_reg + CNT_W'(ctl.do_add && ctl.peak)
                          - CNT_W'(ctl.do_rem && ring_bit);
        better  = ctl.do_best && (cnt_upd > best_reg);
        best_upd   = better ? cnt_upd : best_reg;
        bstart_upd = better ? ctl.start : bstart_reg;
        best_inc   = {1'b0, best_upd} + (CNT_W + 1)'(1);
    end

    always_comb
    begin
        cnt_next       = cnt_reg;
        best_next      = best_reg;
        bstart_next    = bstart_reg;
        parts_next     = parts_reg;
        start_res_next = start_res_reg;
        too_short_next = too_short_reg;
        out_valid_next = out_ready ? 1'b0 : out_valid_reg;

        if (go)
        begin
            if (ctl.last)
            begin
                out_valid_next = 1'b1;
                too_short_next = ctl.too_short;
                parts_next     = ctl.too_short ? '0 : PARTS_W'(best_inc);
                start_res_next = ctl.too_short ? '0 : bstart_upd + START_W'(1);
                cnt_next       = '0;
                best_next      = '0;
                bstart_next    = '0;
            end
            else
            begin
                cnt_next    = cnt_upd;
                best_next   = best_upd;
                bstart_next = bstart_upd;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cnt_reg       <= '0;
            best_reg      <= '0;
            bstart_reg    <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            cnt_reg       <= cnt_next;
            best_reg      <= best_next;
            bstart_reg    <= bstart_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        parts_reg     <= parts_next;
        start_res_reg <= start_res_next;
        too_short_reg <= too_short_next;
    end

    assign out_valid = out_valid_reg;
    assign parts     = parts_reg;
    assign start_res = start_res_reg;
    assign too_short = too_short_reg;
endmodule

/* rtl/core/window_peak_count_max.sv */
// ----------------------------------------------------------------------------
// window_peak_count_max
// Sliding-window local-maxima counter with leftmost best window per stream.
// ----------------------------------------------------------------------------
//  channel   role   beat contents
//  cfg       sink   window_len (11b), applied at the next stream start
//  samples   sink   sample (SAMPLE_BITS, signed), last
//  result    source parts (10b), start_res (17b), too_short
//
//  One sample per cycle while not stalled; the front stage registers a last
//  beat, the tracker its result. The peak-bit ring is read and written at most
//  once per sample, and its registered read data sets the two-stage pipeline.
//  Reset (rst_n low) clears all control and counters; no clearing pass.
//  samples.ready drops only while a last beat waits behind an untaken result.
// ----------------------------------------------------------------------------
`include "window_peak_count_max_macros.svh"

module window_peak_count_max #(
    parameter int MAX_WINDOW  = 1024,
    parameter int MAX_LENGTH  = 65536,
    parameter int SAMPLE_BITS = 32
) (
    input logic          clk,
    input logic          rst_n,
    wpc_cfg_if.sink      cfg,
    wpc_sample_if.sink   samples,
    wpc_result_if.source result
);
    import wpc_pkg::*;

    localparam int AW = $clog2(MAX_WINDOW);

    logic [WLEN_W-1:0] window_len_reg, window_len_next;
    logic              accept, stall;
    logic              ring_we, ring_wdata, ring_re, ring_bit;
    logic [AW-1:0]     ring_waddr, ring_raddr;
    logic              ctl_valid;
    ctl_t              ctl;

    assign cfg.ready       = 1'b1;
    assign window_len_next = (cfg.valid && cfg.ready) ? cfg.window_len : window_len_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            window_len_reg <= WLEN_W'(MIN_WINDOW);
        end
        else
        begin
            window_len_reg <= window_len_next;
        end
    end

    assign samples.ready = !stall;
    assign accept        = samples.valid && samples.ready;

    wpc_front #(
        .MAX_WINDOW  (MAX_WINDOW),
        .MAX_LENGTH  (MAX_LENGTH),
        .SAMPLE_BITS (SAMPLE_BITS)
    ) u_front (
        .clk        (clk),
        .rst_n      (rst_n),
        .accept     (accept),
        .stall      (stall),
        .sample     (samples.sample),
        .last       (samples.last),
        .window_len (window_len_reg),
        .ring_we    (ring_we),
        .ring_waddr (ring_waddr),
        .ring_wdata (ring_wdata),
        .ring_re    (ring_re),
        .ring_raddr (ring_raddr),
        .ctl_valid  (ctl_valid),
        .ctl        (ctl)
    );

    wpc_ring #(
        .DEPTH (MAX_WINDOW)
    ) u_ring (
        .clk   (clk),
        .we    (ring_we),
        .waddr (ring_waddr),
        .wdata (ring_wdata),
        .re    (ring_re),
        .raddr (ring_raddr),
        .rdata (ring_bit)
    );

    wpc_track #(
        .MAX_WINDOW (MAX_WINDOW)
    ) u_track (
        .clk       (clk),
        .rst_n     (rst_n),
        .ctl_valid (ctl_valid),
        .ctl       (ctl),
        .ring_bit  (ring_bit),
        .out_ready (result.ready),
        .stall     (stall),
        .out_valid (result.valid),
        .parts     (result.parts),
        .start_res (result.start_res),
        .too_short (result.too_short)
    );

    // Ring slots read and written by one sample never coincide
    `WPC_ASSERT_NOW(a_ring_no_overlap, ring_we && ring_re, ring_waddr != ring_raddr, "ring read and write hit the same slot")
    // A held last beat must still be there next cycle
    `WPC_ASSERT_NEXT(a_stall_holds, stall, ctl_valid && ctl.last, "stalled last beat lost")
    // A fresh result follows a last beat in the back stage
    `WPC_ASSERT_NOW(a_result_source, $rose(result.valid), $past(ctl_valid && ctl.last), "result without a last beat")
    // Short streams report zero fields
    `WPC_ASSERT_NOW(a_short_zero, result.valid && result.too_short, result.parts == '0 && result.start_res == '0, "short stream with nonzero fields")
endmodule

/* sim/window_peak_count_max_tb.sv */
// ----------------------------------------------------------------------------
// window_peak_count_max_tb
// Self-checking bench for the sliding-window peak counter. Streams of signed
// samples go in over a valid/ready channel with random gaps. A local model
// tracks peaks, window counts and the leftmost best window, and every result
// beat is compared with the oldest predicted one.
// ----------------------------------------------------------------------------
module window_peak_count_max_tb;
    import wpc_pkg::*;

    localparam int MAX_WINDOW  = 1024;
    localparam int MAX_LENGTH  = 65536;
    localparam int SAMPLE_BITS = 32;
    localparam int DRAIN_WAIT  = 8;
    localparam int REPORT_MAX  = 10;

    typedef enum int {
        MODE_SMALL,
        MODE_FULL,
        MODE_EXTREME
    } sample_mode_t;

    typedef struct packed {
        logic [PARTS_W-1:0] parts;
        logic [START_W-1:0] start_res;
        logic               too_short;
    } peak_result_t;

    logic clk;
    logic rst_n;

    wpc_cfg_if                                 cfg_if();
    wpc_sample_if #(.SAMPLE_BITS(SAMPLE_BITS)) samples_if();
    wpc_result_if                              result_if();

    window_peak_count_max #(
        .MAX_WINDOW (MAX_WINDOW),
        .MAX_LENGTH (MAX_LENGTH),
        .SAMPLE_BITS(SAMPLE_BITS)
    ) u_top (
        .clk    (clk),
        .rst_n  (rst_n),
        .cfg    (cfg_if),
        .samples(samples_if),
        .result (result_if)
    );

    // Local copy of the block's stream state
    logic [WLEN_W-1:0]              wlen_reg;
    logic signed [SAMPLE_BITS-1:0]  last_val;
    logic signed [SAMPLE_BITS-1:0]  last2_val;
    bit                             peak_bits [MAX_WINDOW];
    int unsigned                    run_peaks;
    int unsigned                    stream_pos;
    int unsigned                    top_peaks;
    int unsigned                    top_start;
    int unsigned                    cur_win;

    peak_result_t pending_results[$];
    int           mismatches;
    int           samples_sent;
    bit           tx_idle;
    bit           rx_idle;
    int           rx_hold_len;

    initial
    begin
        clk = 1'b0;
        forever #4 clk = ~clk;
    end

    initial
    begin
        #32_000_000;
        $display("window_peak_count_max verification failed");
        $finish;
    end

    function automatic int draw_gap();
        if ($urandom_range(0, 1) == 0)
            return 0;
        return $urandom_range(0, 19);
    endfunction

    function automatic logic signed [SAMPLE_BITS-1:0] pick_sample(sample_mode_t mode);
        logic signed [SAMPLE_BITS-1:0] v;
        case (mode)
            MODE_SMALL: v = int'($urandom_range(0, 6)) - 3;
            MODE_FULL:  v = $urandom;
            default:
            begin
                case ($urandom_range(0, 5))
                    0:       v = {1'b1, {(SAMPLE_BITS-1){1'b0}}};
                    1:       v = {1'b0, {(SAMPLE_BITS-1){1'b1}}};
                    2:       v = '1;
                    3:       v = '0;
                    4:       v = 1;
                    default: v = int'($urandom_range(0, 4)) - 2;
                endcase
            end
        endcase
        return v;
    endfunction

    task automatic clear_stream_state();
        last_val   = '0;
        last2_val  = '0;
        foreach (peak_bits[i])
            peak_bits[i] = 1'b0;
        run_peaks  = 0;
        stream_pos = 0;
        top_peaks  = 0;
        top_start  = 0;
        cur_win    = MIN_WINDOW;
    endtask

    // Advance the stream state by one accepted beat; queue a result on last.
    task automatic track_sample(logic signed [SAMPLE_BITS-1:0] s, logic is_last);
        bit           pk;
        int unsigned  rem;
        peak_result_t r;
        if (stream_pos < MAX_LENGTH)
        begin
            if (stream_pos == 0)
            begin
                cur_win = wlen_reg;
                if (cur_win < MIN_WINDOW)
                    cur_win = MIN_WINDOW;
                if (cur_win > MAX_WINDOW)
                    cur_win = MAX_WINDOW;
            end
            if (stream_pos >= 2)
            begin
                pk = (last_val > last2_val) && (last_val > s);
                peak_bits[(stream_pos - 1) % MAX_WINDOW] = pk;
                run_peaks += pk;
                if (stream_pos + 1 >= cur_win + 1)
                begin
                    rem = stream_pos + 1 - cur_win;
                    if (rem >= 1)
                        run_peaks -= peak_bits[rem % MAX_WINDOW];
                end
            end
            // strict greater keeps the leftmost window
            if (stream_pos + 1 >= cur_win && run_peaks > top_peaks)
            begin
                top_peaks = run_peaks;
                top_start = stream_pos + 1 - cur_win;
            end
            last2_val  = last_val;
            last_val   = s;
            stream_pos = stream_pos + 1;
        end
        if (is_last)
        begin
            if (stream_pos < cur_win)
            begin
                r.parts     = '0;
                r.start_res = '0;
                r.too_short = 1'b1;
            end
            else
            begin
                r.parts     = PARTS_W'(top_peaks + 1);
                r.start_res = START_W'(top_start + 1);
                r.too_short = 1'b0;
            end
            pending_results = {pending_results, r};
            clear_stream_state();
        end
    endtask

    task automatic send_sample(logic signed [SAMPLE_BITS-1:0] s, logic is_last);
        int gap;
        gap = tx_idle ? draw_gap() : 0;
        if (gap > 0)
        begin
            samples_if.valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        samples_if.valid  <= 1'b1;
        samples_if.sample <= s;
        samples_if.last   <= is_last;
        do @(posedge clk); while (!samples_if.ready);
        track_sample(s, is_last);
        samples_sent++;
    endtask

    task automatic send_run(int len, sample_mode_t mode, bit with_last);
        for (int i = 0; i < len; i++)
            send_sample(pick_sample(mode), with_last && (i == len - 1));
    endtask

    // Hold the input until every predicted result is back, then let the
    // pipeline settle.
    task automatic wait_drain();
        samples_if.valid <= 1'b0;
        while (pending_results.size() != 0)
            @(posedge clk);
        repeat (DRAIN_WAIT) @(posedge clk);
    endtask

    task automatic write_window(logic [WLEN_W-1:0] v);
        wait_drain();
        cfg_if.valid      <= 1'b1;
        cfg_if.window_len <= v;
        do @(posedge clk); while (!cfg_if.ready);
        cfg_if.valid <= 1'b0;
        wlen_reg = v;
    endtask

    task automatic check_result();
        peak_result_t got;
        peak_result_t want;
        got.parts     = result_if.parts;
        got.start_res = result_if.start_res;
        got.too_short = result_if.too_short;
        if (pending_results.size() == 0)
        begin
            if (mismatches < REPORT_MAX)
                $display("unexpected result beat: parts %0d start %0d short %0b",
                         got.parts, got.start_res, got.too_short);
            mismatches++;
        end
        else
        begin
            want = pending_results.pop_front();
            if (got.parts !== want.parts || got.start_res !== want.start_res ||
                got.too_short !== want.too_short)
            begin
                if (mismatches < REPORT_MAX)
                    $display("result mismatch: parts %0d/%0d start %0d/%0d short %0b/%0b",
                             want.parts, got.parts, want.start_res, got.start_res,
                             want.too_short, got.too_short);
                mismatches++;
            end
        end
    endtask

    // Result receiver with random stalls and an optional long hold-off
    initial
    begin
        int gap;
        result_if.ready <= 1'b0;
        wait (rst_n === 1'b1);
        @(posedge clk);
        forever
        begin
            gap = rx_idle ? draw_gap() : 0;
            if (rx_hold_len > 0)
            begin
                gap = rx_hold_len;
                rx_hold_len = 0;
            end
            if (gap > 0)
            begin
                result_if.ready <= 1'b0;
                repeat (gap) @(posedge clk);
            end
            result_if.ready <= 1'b1;
            do @(posedge clk); while (!result_if.valid);
            check_result();
        end
    end

    task automatic test_directed();
        logic signed [SAMPLE_BITS-1:0] smin;
        logic signed [SAMPLE_BITS-1:0] smax;
        smin = {1'b1, {(SAMPLE_BITS-1){1'b0}}};
        smax = {1'b0, {(SAMPLE_BITS-1){1'b1}}};
        // alternating extremes, reset window length
        send_sample(smin, 1'b0);
        send_sample(smax, 1'b0);
        send_sample(smin, 1'b0);
        send_sample(smax, 1'b0);
        send_sample(smin, 1'b1);
        // flat runs: equal neighbors never make a peak
        send_sample(0, 1'b0);
        send_sample(0, 1'b0);
        send_sample(0, 1'b0);
        send_sample(5, 1'b0);
        send_sample(5, 1'b0);
        send_sample(-1, 1'b1);
        // streams shorter than the window
        send_sample(smax, 1'b1);
        send_sample(smin, 1'b0);
        send_sample(smax, 1'b1);
        // exactly one window with a single peak
        send_sample(-1, 1'b0);
        send_sample(smax, 1'b0);
        send_sample(-1, 1'b1);
        wait_drain();
    endtask

    task automatic test_window_clamp();
        write_window(0);
        send_run(6, MODE_SMALL, 1'b1);
        write_window(1);
        send_run(7, MODE_EXTREME, 1'b1);
        write_window(2);
        send_run(2, MODE_SMALL, 1'b1);
        send_run(5, MODE_SMALL, 1'b1);
        write_window(2047);
        send_run(10, MODE_FULL, 1'b1);
        send_run(1024, MODE_SMALL, 1'b1);
        write_window(1025);
        send_run(5, MODE_SMALL, 1'b1);
        write_window(4);
        send_run(4, MODE_SMALL, 1'b1);
        wait_drain();
    endtask

    // New length written between beats of a stream applies to the next one.
    task automatic test_cfg_mid_stream();
        write_window(5);
        send_run(4, MODE_SMALL, 1'b0);
        write_window(7);
        send_run(6, MODE_SMALL, 1'b1);
        send_run(12, MODE_SMALL, 1'b1);
        send_run(6, MODE_SMALL, 1'b1);
        wait_drain();
    endtask

    task automatic test_backpressure();
        write_window(3);
        tx_idle = 1'b0;
        rx_hold_len = 300;
        for (int i = 0; i < 20; i++)
            send_run($urandom_range(3, 5), MODE_SMALL, 1'b1);
        // sender pauses here until every result is back
        wait_drain();
        tx_idle = 1'b1;
    endtask

    task automatic test_random_streams();
        int          target;
        int          nstreams;
        int          len;
        int          eff;
        int          sel;
        logic [WLEN_W-1:0] wl;
        sample_mode_t mode;
        target = samples_sent + 560;
        while (samples_sent < target)
        begin
            sel = $urandom_range(0, 99);
            if (sel < 60)
                wl = WLEN_W'($urandom_range(3, 10));
            else if (sel < 85)
                wl = WLEN_W'($urandom_range(11, 40));
            else if (sel < 95)
                wl = WLEN_W'($urandom_range(0, 2));
            else
                wl = WLEN_W'($urandom_range(1025, 2047));
            write_window(wl);
            eff = (wl < MIN_WINDOW) ? MIN_WINDOW : ((wl > MAX_WINDOW) ? MAX_WINDOW : wl);
            // some stretches run with no idling on one or both sides
            tx_idle = ($urandom_range(0, 3) != 0);
            rx_idle = ($urandom_range(0, 3) != 0);
            nstreams = $urandom_range(1, 6);
            for (int i = 0; i < nstreams; i++)
            begin
                len = $urandom_range(1, 2 * eff + 4);
                if (len > 80)
                    len = $urandom_range(1, 80);
                sel = $urandom_range(0, 9);
                mode = (sel < 5) ? MODE_SMALL : ((sel < 8) ? MODE_FULL : MODE_EXTREME);
                send_run(len, mode, 1'b1);
            end
        end
        wait_drain();
        tx_idle = 1'b1;
        rx_idle = 1'b1;
    endtask

    initial
    begin
        samples_if.valid  <= 1'b0;
        samples_if.sample <= '0;
        samples_if.last   <= 1'b0;
        cfg_if.valid      <= 1'b0;
        cfg_if.window_len <= '0;
        rst_n             <= 1'b0;
        wlen_reg     = MIN_WINDOW;
        mismatches   = 0;
        samples_sent = 0;
        tx_idle      = 1'b1;
        rx_idle      = 1'b1;
        rx_hold_len  = 0;
        clear_stream_state();
        repeat (8) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        test_directed();
        test_window_clamp();
        test_cfg_mid_stream();
        test_backpressure();
        test_random_streams();

        wait_drain();
        mismatches += pending_results.size();
        if (mismatches == 0)
            $display("window_peak_count_max verification clean");
        else
            $display("window_peak_count_max verification failed");
        $finish;
    end

endmodule
